>>> hdl/kcd_pkg.sv
// Package for the key click detector: register indexes, reset defaults,
// debounce phase codes and the structs for the lane configuration and lane events.
// No dependencies.
`default_nettype none

package kcd_pkg;

    localparam int KEYS_DEF = 3;

    // Configuration register indexes.
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] REG_SCAN_PERIOD    = 3'd0;
    localparam logic [CFG_IW-1:0] REG_LONG_THRESHOLD = 3'd1;
    localparam logic [CFG_IW-1:0] REG_DOUBLE_WINDOW  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_DOUBLE_ENABLE  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_INVERT_MASK    = 3'd4;

    // Register reset values.
    localparam logic [7:0] SCAN_PERIOD_DEF    = 8'd20;
    localparam logic [7:0] LONG_THRESHOLD_DEF = 8'd60;
    localparam logic [7:0] DOUBLE_WINDOW_DEF  = 8'd25;
    localparam logic       DOUBLE_ENABLE_DEF  = 1'b1;
    localparam int         INVERT_MASK_DEF    = 1;

    localparam logic [7:0] HELD_MAX = 8'd255;

    // Debounce phase codes.
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_CONFIRM = 2'd1;
    localparam logic [1:0] PH_HELD    = 2'd2;

    typedef struct packed {
        logic [7:0] long_threshold;
        logic [7:0] double_window;
        logic       double_enable;
    } t_lane_cfg;

    typedef struct packed {
        logic single;
        logic dbl;
        logic lng;
    } t_lane_evt;

endpackage

`default_nettype wire

>>> hdl/kcd_lane.sv
// One key lane of the click detector: debounce phase, held counter and
// double-click gap window. Depends on kcd_pkg.
`default_nettype none

module kcd_lane
    import kcd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_scan,
    input  wire logic      i_pressed,
    input  wire t_lane_cfg i_cfg,
    output t_lane_evt      o_evt
);

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic [7:0] r_gap, n_gap;
    logic       r_gap_running, n_gap_running;
    logic       r_single_pending, n_single_pending;
    logic [7:0] gap_inc;
    logic [7:0] held_inc;
    t_lane_evt  evt;

    assign gap_inc  = r_gap + 8'd1;
    assign held_inc = (r_held < HELD_MAX) ? (r_held + 8'd1) : r_held;

    always_comb begin
        n_phase          = r_phase;
        n_held           = r_held;
        n_gap            = r_gap;
        n_gap_running    = r_gap_running;
        n_single_pending = r_single_pending;
        evt              = '0;
        if (i_scan) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_pressed) begin
                        n_phase = PH_CONFIRM;
                    end else if (i_cfg.double_enable && r_gap_running) begin
                        n_gap = gap_inc;
                        if (gap_inc >= i_cfg.double_window) begin
                            // Window expired: report the click left waiting.
                            n_gap            = '0;
                            n_gap_running    = 1'b0;
                            evt.single       = r_single_pending;
                            n_single_pending = 1'b0;
                        end
                    end
                end
                PH_CONFIRM: begin
                    if (i_pressed) begin
                        n_phase = PH_HELD;
                        n_held  = '0;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_HELD: begin
                    if (!i_pressed) begin
                        n_phase = PH_IDLE;
                        if (r_held < i_cfg.long_threshold) begin
                            if (!i_cfg.double_enable) begin
                                evt.single = 1'b1;
                            end else if (r_gap_running) begin
                                evt.dbl          = 1'b1;
                                n_single_pending = 1'b0;
                                n_gap            = '0;
                                n_gap_running    = 1'b0;
                            end else begin
                                n_single_pending = 1'b1;
                                n_gap_running    = 1'b1;
                            end
                        end
                    end else begin
                        n_held  = held_inc;
                        evt.lng = (held_inc > i_cfg.long_threshold);
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_held           <= '0;
            r_gap            <= '0;
            r_gap_running    <= 1'b0;
            r_single_pending <= 1'b0;
        end else begin
            r_phase          <= n_phase;
            r_held           <= n_held;
            r_gap            <= n_gap;
            r_gap_running    <= n_gap_running;
            r_single_pending <= n_single_pending;
        end
    end

    assign o_evt = evt;

    a_one_click_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(evt.single && evt.dbl))
        else $error("single and double click in the same scan");

    a_double_closes_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        evt.dbl |=> !r_gap_running && !r_single_pending)
        else $error("gap window still open after a double click");

    a_long_only_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        evt.lng |=> r_phase == PH_HELD)
        else $error("long press reported while key not held");

    a_no_event_without_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_scan |-> evt == '0)
        else $error("key event outside a scan");

endmodule

`default_nettype wire

>>> hdl/kcd_merge.sv
// Merge stage: gathers the lane events into per-scan masks and holds the
// result in the output register of the master stream. Depends on kcd_pkg.
`default_nettype none

module kcd_merge
    import kcd_pkg::*;
#(
    parameter int KEYS  = KEYS_DEF,
    parameter int OUT_W = ((1 + 3 * KEYS + 7) / 8) * 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_load,
    input  wire logic                  i_scan,
    input  wire t_lane_evt [KEYS-1:0]  i_evt,
    output logic                       o_space,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // From bit 0: scan_done, single_mask, double_mask, long_mask, zero fill.
    output logic [OUT_W-1:0]           o_m_axis_tdata
);

    logic [KEYS-1:0]  single_mask;
    logic [KEYS-1:0]  double_mask;
    logic [KEYS-1:0]  long_mask;
    logic             r_valid;
    logic [OUT_W-1:0] r_data;
    logic [OUT_W-1:0] n_data;

    always_comb begin
        for (int k = 0; k < KEYS; k++) begin
            single_mask[k] = i_evt[k].single;
            double_mask[k] = i_evt[k].dbl;
            long_mask[k]   = i_evt[k].lng;
        end
    end

    assign n_data  = OUT_W'({long_mask, double_mask, single_mask, i_scan});
    // A new transaction may enter when the register is empty or drains this cycle.
    assign o_space = !r_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_data;

    a_load_gives_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_valid)
        else $error("loaded result not presented");

    a_quiet_tick_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_data[0]) |-> r_data[3*KEYS:1] == '0)
        else $error("event bits set on a tick without scan");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_m_axis_tready) |-> !i_load)
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

>>> hdl/key_click_double_long_detector.sv
// Key click detector top level: one transaction per 1 ms tick in, one result out.
// An accepted tick's result is registered and appears on the master stream in the next cycle.
// One tick per cycle while the master stream takes results; the output register refills in the cycle it drains.
// All lanes update in the cycle a scanning tick is accepted; the merge register holds the result.
// Synchronous active-low reset clears prescaler, key state and output valid and
// loads the register defaults. Depends on kcd_pkg, kcd_lane, kcd_merge.
`default_nettype none

module key_click_double_long_detector
    import kcd_pkg::*;
#(
    parameter int KEYS   = KEYS_DEF,
    parameter int IN_W   = ((KEYS + 7) / 8) * 8,
    parameter int OUT_W  = ((1 + 3 * KEYS + 7) / 8) * 8,
    parameter int CFG_DW = (KEYS > 8) ? KEYS : 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // From bit 0: pin_levels, zero fill.
    input  wire logic [IN_W-1:0]   i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    // From bit 0: scan_done, single_mask, double_mask, long_mask, zero fill.
    output logic [OUT_W-1:0]       o_m_axis_tdata,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [CFG_DW-1:0] i_cfg_data
);

    logic [7:0]      r_scan_period;
    logic [7:0]      r_long_threshold;
    logic [7:0]      r_double_window;
    logic            r_double_enable;
    logic [KEYS-1:0] r_invert_mask;
    logic [7:0]      r_tick, n_tick;
    logic [7:0]      tick_inc;
    logic            accept;
    logic            space;
    logic            scan_fire;
    logic            scan;
    logic [KEYS-1:0] levels;
    t_lane_cfg       lane_cfg;
    t_lane_evt [KEYS-1:0] evt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_period    <= SCAN_PERIOD_DEF;
            r_long_threshold <= LONG_THRESHOLD_DEF;
            r_double_window  <= DOUBLE_WINDOW_DEF;
            r_double_enable  <= DOUBLE_ENABLE_DEF;
            r_invert_mask    <= KEYS'(INVERT_MASK_DEF);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SCAN_PERIOD:    r_scan_period    <= i_cfg_data[7:0];
                REG_LONG_THRESHOLD: r_long_threshold <= i_cfg_data[7:0];
                REG_DOUBLE_WINDOW:  r_double_window  <= i_cfg_data[7:0];
                REG_DOUBLE_ENABLE:  r_double_enable  <= i_cfg_data[0];
                REG_INVERT_MASK:    r_invert_mask    <= i_cfg_data[KEYS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_s_axis_tready = space;
    assign accept          = i_s_axis_tvalid && space;

    // Prescaler: the counter restarts at zero on the tick that scans.
    assign tick_inc  = r_tick + 8'd1;
    assign scan_fire = !(tick_inc < r_scan_period);
    assign scan      = accept && scan_fire;
    assign n_tick    = scan_fire ? 8'd0 : tick_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
        end else if (accept) begin
            r_tick <= n_tick;
        end
    end

    assign levels = i_s_axis_tdata[KEYS-1:0] ^ r_invert_mask;

    assign lane_cfg.long_threshold = r_long_threshold;
    assign lane_cfg.double_window  = r_double_window;
    assign lane_cfg.double_enable  = r_double_enable;

    for (genvar k = 0; k < KEYS; k++) begin : g_lane
        kcd_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_scan    (scan),
            .i_pressed (!levels[k]),
            .i_cfg     (lane_cfg),
            .o_evt     (evt[k])
        );
    end

    kcd_merge #(
        .KEYS  (KEYS),
        .OUT_W (OUT_W)
    ) u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (accept),
        .i_scan          (scan),
        .i_evt           (evt),
        .o_space         (space),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    a_tick_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan |=> r_tick == 8'd0)
        else $error("prescaler did not restart after a scan");

    a_tick_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_tick))
        else $error("prescaler moved without a transaction");

    a_scan_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_m_axis_tdata[0] == $past(scan_fire))
        else $error("scan flag does not match the prescaler");

endmodule

`default_nettype wire
